// ===== design/round_robin_task_scheduler_core_defines.svh =====
// Assertion macros for the scheduler RTL.
`ifndef ROUND_ROBIN_TASK_SCHEDULER_CORE_DEFINES_SVH
`define ROUND_ROBIN_TASK_SCHEDULER_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// Check a property on every clock edge outside reset.
`define RRTS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Check a property on every clock edge, reset included.
`define RRTS_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define RRTS_ASSERT(lbl, prop, msg)
`define RRTS_ASSERT_RST(lbl, prop, msg)
`endif

`endif

// ===== design/rrts_pkg.sv =====
// Types, sizes and codes shared by the round-robin task scheduler.
package rrts_pkg;

  localparam int TASK_SLOTS = 64;
  localparam int SLOT_W     = $clog2(TASK_SLOTS);
  localparam int CNT_W      = $clog2(TASK_SLOTS + 1);

  localparam int OP_W     = 3;
  localparam int HANDLE_W = 16;
  localparam int BITS_W   = 2;
  localparam int STATUS_W = 3;
  localparam int TID_W    = 6;
  localparam int WOKEN_W  = 7;

  typedef enum logic [OP_W-1:0] {
    OP_SPAWN    = 3'd0,
    OP_YIELD    = 3'd1,
    OP_BLOCK    = 3'd2,
    OP_FINISH   = 3'd3,
    OP_EVENT    = 3'd4,
    OP_DISPATCH = 3'd5
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    STS_OK       = 3'd0,
    STS_FULL     = 3'd1,
    STS_NO_TASK  = 3'd2,
    STS_BUSY     = 3'd3,
    STS_WAIT_IO  = 3'd4,
    STS_ALL_DONE = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    SL_FREE    = 2'd0,
    SL_READY   = 2'd1,
    SL_RUNNING = 2'd2,
    SL_BLOCKED = 2'd3
  } slot_state_t;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_FINISH
  } fsm_state_t;

  typedef struct packed {
    slot_state_t         st;
    logic [HANDLE_W-1:0] handle;
    logic [BITS_W-1:0]   mask;
  } slot_entry_t;

  localparam int ENTRY_W = $bits(slot_entry_t);

  typedef struct packed {
    logic [OP_W-1:0]     op;
    logic [HANDLE_W-1:0] io_handle;
    logic [BITS_W-1:0]   want_bits;
    logic [BITS_W-1:0]   ready_bits;
    logic                io_error;
  } sched_req_t;

  typedef struct packed {
    logic               done;
    status_t            status;
    logic [TID_W-1:0]   task_id;
    logic [WOKEN_W-1:0] woken_count;
  } sched_res_t;

  typedef struct packed {
    logic              we;
    logic [SLOT_W-1:0] addr;
    slot_entry_t       data;
  } ram_wr_t;

  typedef struct packed {
    logic              re;
    logic [SLOT_W-1:0] addr;
  } ram_rd_t;

endpackage

// ===== design/round_robin_task_scheduler_core.sv =====
// Top level of the round-robin task scheduler: slot table RAM, sequencer, result register.
//
// Usage:
//   Command channel: drive in_op and its fields with start high; the command
//   transfer happens at a rising edge where start is high and busy is low.
//   One command is in flight at a time; busy stays high until its result
//   has been issued.
//   Result channel: out_valid pulses for exactly one cycle with out_status,
//   out_task_id and out_woken_count. The receiver cannot stall, so capture
//   the result in the strobe cycle.
//   Command flow: yield, block, finish, rejected commands and unused op codes
//   go from idle straight to the finish state. Spawn, io ready event and dispatch scan
//   the slot table through the RAM read port, one slot per cycle; spawn and
//   dispatch stop at the first slot they find, an io ready event reads every
//   slot, and a scan that finds nothing runs to the end of the table.
//   Commands can follow one another once busy drops.
//   Reset: synchronous, active low. After reset a clearing pass writes every
//   slot free, one slot per cycle, with busy high; then no task runs and the
//   round-robin cursor is at slot zero.
module round_robin_task_scheduler_core (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic [rrts_pkg::OP_W-1:0]       in_op,
  input  logic [rrts_pkg::HANDLE_W-1:0]   in_io_handle,
  input  logic [rrts_pkg::BITS_W-1:0]     in_want_bits,
  input  logic [rrts_pkg::BITS_W-1:0]     in_ready_bits,
  input  logic                            in_io_error,
  output logic                            out_valid,
  output logic [rrts_pkg::STATUS_W-1:0]   out_status,
  output logic [rrts_pkg::TID_W-1:0]      out_task_id,
  output logic [rrts_pkg::WOKEN_W-1:0]    out_woken_count
);

  rrts_pkg::sched_req_t  req;
  rrts_pkg::sched_res_t  res;
  rrts_pkg::ram_wr_t     ram_wr;
  rrts_pkg::ram_rd_t     ram_rd;
  rrts_pkg::slot_entry_t ram_rdata;

  logic                              out_valid_r;
  logic [rrts_pkg::STATUS_W-1:0]     out_status_r;
  logic [rrts_pkg::TID_W-1:0]        out_task_id_r;
  logic [rrts_pkg::WOKEN_W-1:0]      out_woken_count_r;

  // Bundle the command fields for the sequencer.
  always_comb begin
    req.op         = in_op;
    req.io_handle  = in_io_handle;
    req.want_bits  = in_want_bits;
    req.ready_bits = in_ready_bits;
    req.io_error   = in_io_error;
  end

  // Slot table: state, wait handle and wanted bits of each slot in one word.
  rrts_ram #(
    .WIDTH(rrts_pkg::ENTRY_W),
    .DEPTH(rrts_pkg::TASK_SLOTS)
  ) u_slot_ram (
    .clk  (clk),
    .we   (ram_wr.we),
    .waddr(ram_wr.addr),
    .wdata(ram_wr.data),
    .re   (ram_rd.re),
    .raddr(ram_rd.addr),
    .rdata(ram_rdata)
  );

  rrts_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .req      (req),
    .busy     (busy),
    .res      (res),
    .ram_wr   (ram_wr),
    .ram_rd   (ram_rd),
    .ram_rdata(ram_rdata)
  );

  // Hold the strobe for one cycle only; drop it on reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= res.done;
    end
  end

  // Capture the result fields when the sequencer finishes a command.
  always_ff @(posedge clk) begin
    if (res.done) begin
      out_status_r      <= res.status;
      out_task_id_r     <= res.task_id;
      out_woken_count_r <= res.woken_count;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_task_id     = out_task_id_r;
  assign out_woken_count = out_woken_count_r;

endmodule

// ===== design/rrts_ram.sv =====
// Generic simple dual-port RAM with registered read data.
module rrts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== design/rrts_ctrl.sv =====
// Scheduler sequencer: table clearing, operation decode and slot table scans.
`include "round_robin_task_scheduler_core_defines.svh"

module rrts_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  rrts_pkg::sched_req_t req,
  output logic                 busy,
  output rrts_pkg::sched_res_t res,
  output rrts_pkg::ram_wr_t    ram_wr,
  output rrts_pkg::ram_rd_t    ram_rd,
  input  rrts_pkg::slot_entry_t ram_rdata
);

  localparam int N      = rrts_pkg::TASK_SLOTS;
  localparam int SLOT_W = rrts_pkg::SLOT_W;
  localparam int CNT_W  = rrts_pkg::CNT_W;

  rrts_pkg::fsm_state_t state_r, state_nxt;

  logic [SLOT_W-1:0]   clr_r, clr_nxt;
  rrts_pkg::op_t       op_r, op_nxt;
  logic [rrts_pkg::HANDLE_W-1:0] handle_r, handle_nxt;
  logic [rrts_pkg::BITS_W-1:0]   ready_r, ready_nxt;
  logic                err_r, err_nxt;
  rrts_pkg::status_t   status_r, status_nxt;
  logic [SLOT_W-1:0]   tid_r, tid_nxt;
  logic [CNT_W-1:0]    woken_r, woken_nxt;
  logic                any_blk_r, any_blk_nxt;
  logic [CNT_W-1:0]    iss_cnt_r, iss_cnt_nxt;
  logic [SLOT_W-1:0]   base_r, base_nxt;
  logic                rd_vld_r, rd_vld_nxt;
  logic [SLOT_W-1:0]   rd_addr_r, rd_addr_nxt;
  logic                cur_valid_r, cur_valid_nxt;
  logic [SLOT_W-1:0]   cur_slot_r, cur_slot_nxt;
  logic [SLOT_W-1:0]   cursor_r, cursor_nxt;

  rrts_pkg::op_t     in_op;
  logic              accept;
  logic              hit;
  logic              wake;
  logic              issue;
  logic              scan_end;
  logic [SLOT_W:0]   addr_sum;
  logic [SLOT_W-1:0] scan_addr;
  logic [SLOT_W-1:0] cursor_inc;

  assign in_op  = rrts_pkg::op_t'(req.op);
  assign busy   = (state_r != rrts_pkg::S_IDLE);
  assign accept = start && (state_r == rrts_pkg::S_IDLE);

  // Scan evaluation: address of the next read and checks on returned data.
  always_comb begin
    addr_sum = {1'b0, base_r} + {1'b0, iss_cnt_r[SLOT_W-1:0]};
    if (addr_sum >= (SLOT_W+1)'(N)) begin
      addr_sum = addr_sum - (SLOT_W+1)'(N);
    end
    scan_addr  = addr_sum[SLOT_W-1:0];
    cursor_inc = (rd_addr_r == SLOT_W'(N - 1)) ? '0 : rd_addr_r + 1'b1;

    hit = (state_r == rrts_pkg::S_SCAN) && rd_vld_r &&
          (((op_r == rrts_pkg::OP_SPAWN) && (ram_rdata.st == rrts_pkg::SL_FREE)) ||
           ((op_r == rrts_pkg::OP_DISPATCH) && (ram_rdata.st == rrts_pkg::SL_READY)));
    wake = (state_r == rrts_pkg::S_SCAN) && rd_vld_r && (op_r == rrts_pkg::OP_EVENT) &&
           (ram_rdata.st == rrts_pkg::SL_BLOCKED) && (ram_rdata.handle == handle_r) &&
           (err_r || ((ram_rdata.mask & ready_r) != '0));
    issue    = (state_r == rrts_pkg::S_SCAN) && (iss_cnt_r < CNT_W'(N)) && !hit;
    scan_end = (state_r == rrts_pkg::S_SCAN) && (iss_cnt_r == CNT_W'(N)) && !rd_vld_r;
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      rrts_pkg::S_CLEAR: begin
        if (clr_r == SLOT_W'(N - 1)) begin
          state_nxt = rrts_pkg::S_IDLE;
        end
      end
      rrts_pkg::S_IDLE: begin
        if (accept) begin
          unique case (in_op) inside
            rrts_pkg::OP_SPAWN, rrts_pkg::OP_EVENT: state_nxt = rrts_pkg::S_SCAN;
            rrts_pkg::OP_DISPATCH: begin
              state_nxt = cur_valid_r ? rrts_pkg::S_FINISH : rrts_pkg::S_SCAN;
            end
            default: state_nxt = rrts_pkg::S_FINISH;
          endcase
        end
      end
      rrts_pkg::S_SCAN: begin
        if (hit || scan_end) begin
          state_nxt = rrts_pkg::S_FINISH;
        end
      end
      rrts_pkg::S_FINISH: state_nxt = rrts_pkg::S_IDLE;
      default: state_nxt = rrts_pkg::S_IDLE;
    endcase
  end

  // Datapath and memory port control
  always_comb begin
    clr_nxt       = clr_r;
    op_nxt        = op_r;
    handle_nxt    = handle_r;
    ready_nxt     = ready_r;
    err_nxt       = err_r;
    status_nxt    = status_r;
    tid_nxt       = tid_r;
    woken_nxt     = woken_r;
    any_blk_nxt   = any_blk_r;
    iss_cnt_nxt   = iss_cnt_r;
    base_nxt      = base_r;
    rd_vld_nxt    = 1'b0;
    rd_addr_nxt   = rd_addr_r;
    cur_valid_nxt = cur_valid_r;
    cur_slot_nxt  = cur_slot_r;
    cursor_nxt    = cursor_r;
    ram_wr        = '0;
    ram_rd        = '0;

    unique case (state_r)
      rrts_pkg::S_CLEAR: begin
        ram_wr.we          = 1'b1;
        ram_wr.addr        = clr_r;
        ram_wr.data.st     = rrts_pkg::SL_FREE;
        ram_wr.data.handle = '0;
        ram_wr.data.mask   = '0;
        clr_nxt            = clr_r + 1'b1;
      end
      rrts_pkg::S_IDLE: begin
        if (accept) begin
          op_nxt      = in_op;
          handle_nxt  = req.io_handle;
          ready_nxt   = req.ready_bits;
          err_nxt     = req.io_error;
          status_nxt  = rrts_pkg::STS_OK;
          tid_nxt     = '0;
          woken_nxt   = '0;
          any_blk_nxt = 1'b0;
          iss_cnt_nxt = '0;
          base_nxt    = (in_op == rrts_pkg::OP_DISPATCH) ? cursor_r : '0;
          unique case (in_op) inside
            rrts_pkg::OP_YIELD, rrts_pkg::OP_BLOCK, rrts_pkg::OP_FINISH: begin
              if (!cur_valid_r) begin
                status_nxt = rrts_pkg::STS_NO_TASK;
              end else begin
                ram_wr.we          = 1'b1;
                ram_wr.addr        = cur_slot_r;
                ram_wr.data.handle = req.io_handle;
                ram_wr.data.mask   = req.want_bits;
                if (in_op == rrts_pkg::OP_YIELD) begin
                  ram_wr.data.st = rrts_pkg::SL_READY;
                end else if (in_op == rrts_pkg::OP_BLOCK) begin
                  ram_wr.data.st = rrts_pkg::SL_BLOCKED;
                end else begin
                  ram_wr.data.st = rrts_pkg::SL_FREE;
                end
                cur_valid_nxt = 1'b0;
              end
            end
            rrts_pkg::OP_DISPATCH: begin
              if (cur_valid_r) begin
                status_nxt = rrts_pkg::STS_BUSY;
              end
            end
            default: ;
          endcase
        end
      end
      rrts_pkg::S_SCAN: begin
        ram_rd.re   = issue;
        ram_rd.addr = scan_addr;
        rd_vld_nxt  = issue;
        rd_addr_nxt = scan_addr;
        if (issue) begin
          iss_cnt_nxt = iss_cnt_r + 1'b1;
        end
        // Each entry is read once per scan, so write-back never meets a read.
        if (wake) begin
          ram_wr.we      = 1'b1;
          ram_wr.addr    = rd_addr_r;
          ram_wr.data    = ram_rdata;
          ram_wr.data.st = rrts_pkg::SL_READY;
          woken_nxt      = woken_r + 1'b1;
        end
        if (rd_vld_r && (op_r == rrts_pkg::OP_DISPATCH) &&
            (ram_rdata.st == rrts_pkg::SL_BLOCKED)) begin
          any_blk_nxt = 1'b1;
        end
        if (hit) begin
          ram_wr.we   = 1'b1;
          ram_wr.addr = rd_addr_r;
          tid_nxt     = rd_addr_r;
          if (op_r == rrts_pkg::OP_SPAWN) begin
            ram_wr.data.st     = rrts_pkg::SL_READY;
            ram_wr.data.handle = handle_r;
            ram_wr.data.mask   = '0;
          end else begin
            ram_wr.data    = ram_rdata;
            ram_wr.data.st = rrts_pkg::SL_RUNNING;
            cur_valid_nxt  = 1'b1;
            cur_slot_nxt   = rd_addr_r;
            cursor_nxt     = cursor_inc;
          end
        end
        if (scan_end) begin
          if (op_r == rrts_pkg::OP_SPAWN) begin
            status_nxt = rrts_pkg::STS_FULL;
          end else if (op_r == rrts_pkg::OP_DISPATCH) begin
            status_nxt = any_blk_r ? rrts_pkg::STS_WAIT_IO : rrts_pkg::STS_ALL_DONE;
          end
        end
      end
      rrts_pkg::S_FINISH: ;
      default: ;
    endcase
  end

  always_comb begin
    res.done        = (state_r == rrts_pkg::S_FINISH);
    res.status      = status_r;
    res.task_id     = rrts_pkg::TID_W'(tid_r);
    res.woken_count = rrts_pkg::WOKEN_W'(woken_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rrts_pkg::S_CLEAR;
      clr_r       <= '0;
      iss_cnt_r   <= '0;
      rd_vld_r    <= 1'b0;
      cur_valid_r <= 1'b0;
      cur_slot_r  <= '0;
      cursor_r    <= '0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      iss_cnt_r   <= iss_cnt_nxt;
      rd_vld_r    <= rd_vld_nxt;
      cur_valid_r <= cur_valid_nxt;
      cur_slot_r  <= cur_slot_nxt;
      cursor_r    <= cursor_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r      <= op_nxt;
    handle_r  <= handle_nxt;
    ready_r   <= ready_nxt;
    err_r     <= err_nxt;
    status_r  <= status_nxt;
    tid_r     <= tid_nxt;
    woken_r   <= woken_nxt;
    any_blk_r <= any_blk_nxt;
    base_r    <= base_nxt;
    rd_addr_r <= rd_addr_nxt;
  end

  `RRTS_ASSERT(a_no_rw_same_entry, (ram_wr.we && ram_rd.re) |-> (ram_wr.addr != ram_rd.addr), "read and write hit the same slot")
  `RRTS_ASSERT(a_run_from_dispatch, $rose(cur_valid_r) |-> ($past(state_r) == rrts_pkg::S_SCAN && $past(op_r) == rrts_pkg::OP_DISPATCH), "task started outside a dispatch scan")
  `RRTS_ASSERT(a_done_to_idle, res.done |=> (state_r == rrts_pkg::S_IDLE), "result not followed by idle")
  `RRTS_ASSERT(a_issue_bound, iss_cnt_r <= CNT_W'(N), "scan issued past the table")
  `RRTS_ASSERT_RST(a_reset_clears, !rst_n |=> (state_r == rrts_pkg::S_CLEAR), "reset did not start table clearing")

endmodule

// ===== bench/tb.sv =====
// Self-checking testbench for the round-robin task scheduler core.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rrts_pkg::*;

  // Op codes the block accepts but ignores.
  localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;

  // Longest scan plus margin; used for the quiet time at the end.
  localparam int SETTLE_CYCLES = TASK_SLOTS + 40;
  localparam int MAX_PRINTS    = 100;

  typedef struct {
    status_t            status;
    logic [TID_W-1:0]   task_id;
    logic [WOKEN_W-1:0] woken;
  } sched_outcome_t;

  logic                clk;
  logic                rst_n;
  logic                start;
  logic                busy;
  logic [OP_W-1:0]     in_op;
  logic [HANDLE_W-1:0] in_io_handle;
  logic [BITS_W-1:0]   in_want_bits;
  logic [BITS_W-1:0]   in_ready_bits;
  logic                in_io_error;
  logic                out_valid;
  logic [STATUS_W-1:0] out_status;
  logic [TID_W-1:0]    out_task_id;
  logic [WOKEN_W-1:0]  out_woken_count;

  round_robin_task_scheduler_core u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_op           (in_op),
    .in_io_handle    (in_io_handle),
    .in_want_bits    (in_want_bits),
    .in_ready_bits   (in_ready_bits),
    .in_io_error     (in_io_error),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_task_id     (out_task_id),
    .out_woken_count (out_woken_count)
  );

  // Shadow copy of the slot table and the dispatcher registers.
  slot_state_t         slot_st     [TASK_SLOTS];
  logic [HANDLE_W-1:0] slot_handle [TASK_SLOTS];
  logic [BITS_W-1:0]   slot_mask   [TASK_SLOTS];
  bit                  run_valid;
  int                  run_slot;
  int                  rr_cursor;

  sched_outcome_t      expected_results [$];
  sched_outcome_t      head_result;
  int                  mismatch_count;

  // Handles that block and wake items mostly draw from, so events find waiters.
  logic [HANDLE_W-1:0] handle_pool [4];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop in case the block hangs; far beyond the slowest legal run.
  initial begin
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

  // Advance the shadow model by one command and return what the block must answer.
  function automatic sched_outcome_t schedule_step(
    input logic [OP_W-1:0]     op,
    input logic [HANDLE_W-1:0] handle,
    input logic [BITS_W-1:0]   want,
    input logic [BITS_W-1:0]   ready,
    input logic                err
  );
    sched_outcome_t res;
    bit             found;
    bit             any_blocked;
    int             t;
    res.status  = STS_OK;
    res.task_id = '0;
    res.woken   = '0;
    found       = 1'b0;
    any_blocked = 1'b0;
    t           = 0;
    case (op)
      OP_SPAWN: begin
        // Claim the lowest free slot; a full table changes nothing.
        res.status = STS_FULL;
        for (int i = 0; i < TASK_SLOTS; i++) begin
          if (!found && slot_st[i] == SL_FREE) begin
            found        = 1'b1;
            slot_st[i]   = SL_READY;
            slot_mask[i] = '0;
            res.task_id  = TID_W'(i);
            res.status   = STS_OK;
          end
        end
      end
      OP_YIELD, OP_BLOCK, OP_FINISH: begin
        if (!run_valid) begin
          res.status = STS_NO_TASK;
        end else begin
          if (op == OP_YIELD) begin
            slot_st[run_slot] = SL_READY;
          end else if (op == OP_BLOCK) begin
            slot_handle[run_slot] = handle;
            slot_mask[run_slot]   = want;
            slot_st[run_slot]     = SL_BLOCKED;
          end else begin
            slot_st[run_slot] = SL_FREE;
          end
          run_valid = 1'b0;
        end
      end
      OP_EVENT: begin
        // Wake every waiter on this handle whose wanted bits hit, or all on error.
        for (int i = 0; i < TASK_SLOTS; i++) begin
          if (slot_st[i] == SL_BLOCKED && slot_handle[i] == handle &&
              (err || (slot_mask[i] & ready) != '0)) begin
            slot_st[i] = SL_READY;
            res.woken  = res.woken + 1'b1;
          end
        end
      end
      OP_DISPATCH: begin
        if (run_valid) begin
          res.status = STS_BUSY;
        end else begin
          for (int s = 0; s < TASK_SLOTS; s++) begin
            if (!found && slot_st[(rr_cursor + s) % TASK_SLOTS] == SL_READY) begin
              found = 1'b1;
              t     = (rr_cursor + s) % TASK_SLOTS;
            end
          end
          if (found) begin
            slot_st[t]  = SL_RUNNING;
            run_slot    = t;
            run_valid   = 1'b1;
            rr_cursor   = (t + 1) % TASK_SLOTS;
            res.task_id = TID_W'(t);
          end else begin
            for (int i = 0; i < TASK_SLOTS; i++) begin
              if (slot_st[i] == SL_BLOCKED) any_blocked = 1'b1;
            end
            res.status = any_blocked ? STS_WAIT_IO : STS_ALL_DONE;
          end
        end
      end
      default: begin
      end
    endcase
    return res;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    if (mismatch_count < MAX_PRINTS) begin
      $display("tb: mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    end
    mismatch_count++;
  endtask

  // Check every strobed result against the oldest outstanding prediction.
  // Sample at the edge that closes the strobe cycle, before the block updates.
  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_valid === 1'b1) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result, status", int'(out_status), 0);
      end else begin
        head_result = expected_results.pop_front();
        if (out_status !== head_result.status) begin
          report_mismatch("status", int'(out_status), int'(head_result.status));
        end
        if (out_task_id !== head_result.task_id) begin
          report_mismatch("task_id", int'(out_task_id), int'(head_result.task_id));
        end
        if (out_woken_count !== head_result.woken) begin
          report_mismatch("woken_count", int'(out_woken_count), int'(head_result.woken));
        end
      end
    end
  end

  // Drive one command and hold it until the transfer; call and return at a rising edge.
  // Start stays high on return so back-to-back commands need no extra edge.
  task automatic send_op(
    input logic [OP_W-1:0]     op,
    input logic [HANDLE_W-1:0] handle,
    input logic [BITS_W-1:0]   want,
    input logic [BITS_W-1:0]   ready,
    input logic                err
  );
    in_op         <= op;
    in_io_handle  <= handle;
    in_want_bits  <= want;
    in_ready_bits <= ready;
    in_io_error   <= err;
    start         <= 1'b1;
    // Busy is registered: a low value at the falling edge holds through the next rising edge.
    do @(negedge clk); while (busy !== 1'b0);
    @(posedge clk);
    expected_results.push_back(schedule_step(op, handle, want, ready, err));
  endtask

  task automatic hold_off(input int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  task automatic wait_for_results();
    start <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  task automatic refresh_handle_pool();
    for (int i = 0; i < 4; i++) handle_pool[i] = HANDLE_W'($urandom_range(0, 65535));
  endtask

  // Pick an op that mostly keeps task lifecycles well formed, with some noise mixed in.
  function automatic logic [OP_W-1:0] pick_op(input bit spawn_heavy);
    int r;
    r = $urandom_range(0, 99);
    if (run_valid) begin
      if (r < 28)      return OP_YIELD;
      else if (r < 50) return OP_BLOCK;
      else if (r < 62) return spawn_heavy ? OP_YIELD : OP_FINISH;
      else if (r < 68) return OP_DISPATCH;
      else if (r < 80) return OP_SPAWN;
      else if (r < 92) return OP_EVENT;
      else if (r < 96) return ($urandom_range(0, 1) != 0) ? OP_SPARE_LO : OP_SPARE_HI;
      else             return OP_W'($urandom_range(0, 7));
    end else begin
      if (r < 42)      return OP_DISPATCH;
      else if (r < 62) return spawn_heavy ? OP_SPAWN : OP_DISPATCH;
      else if (r < 72) return OP_SPAWN;
      else if (r < 88) return OP_EVENT;
      else if (r < 95) return OP_W'($urandom_range(1, 3));
      else             return OP_W'($urandom_range(0, 7));
    end
  endfunction

  task automatic random_traffic(input int count, input bit with_gaps, input bit spawn_heavy);
    logic [OP_W-1:0]     op;
    logic [HANDLE_W-1:0] handle;
    logic                err;
    for (int n = 0; n < count; n++) begin
      op     = pick_op(spawn_heavy);
      // Fill the don't-care fields with noise too.
      handle = HANDLE_W'($urandom_range(0, 65535));
      if ((op == OP_BLOCK || op == OP_EVENT) && $urandom_range(0, 99) < 85) begin
        handle = handle_pool[$urandom_range(0, 3)];
      end
      err = (op == OP_EVENT) ? ($urandom_range(0, 4) == 0) : 1'($urandom_range(0, 1));
      send_op(op, handle, BITS_W'($urandom_range(0, 3)), BITS_W'($urandom_range(0, 3)), err);
      if (with_gaps && $urandom_range(0, 4) == 0) hold_off($urandom_range(1, 17));
    end
  endtask

  // Empty-table answers, rejected commands, spare op codes, wake rules and cursor wrap.
  task automatic test_directed_ops();
    send_op(OP_DISPATCH, '0, '0, '0, 1'b0);        // nothing at all: all finished
    send_op(OP_YIELD,    '0, '0, '0, 1'b0);        // no running task
    send_op(OP_BLOCK,    16'hFFFF, 2'd3, 2'd3, 1'b1);
    send_op(OP_FINISH,   '0, '0, '0, 1'b0);
    send_op(OP_EVENT,    '0, '0, 2'd3, 1'b1);      // event with nobody waiting
    send_op(OP_SPARE_LO, 16'hFFFF, 2'd3, 2'd3, 1'b1);
    send_op(OP_SPARE_HI, 16'hFFFF, 2'd3, 2'd3, 1'b1);
    send_op(OP_SPAWN,    '0, '0, '0, 1'b0);
    send_op(OP_SPAWN,    16'hFFFF, 2'd3, 2'd3, 1'b1);
    send_op(OP_DISPATCH, '0, '0, '0, 1'b0);
    send_op(OP_DISPATCH, '0, '0, '0, 1'b0);        // dispatch while a task runs
    send_op(OP_BLOCK,    16'hFFFF, 2'd0, '0, 1'b0); // empty mask wakes only on error
    send_op(OP_DISPATCH, '0, '0, '0, 1'b0);
    send_op(OP_BLOCK,    16'hFFFF, 2'd1, '0, 1'b0);
    send_op(OP_DISPATCH, '0, '0, '0, 1'b0);        // only blocked tasks: waiting on io
    send_op(OP_EVENT,    16'hFFFF, '0, 2'd2, 1'b0); // wrong bits
    send_op(OP_EVENT,    16'hFFFE, '0, 2'd3, 1'b1); // wrong handle
    send_op(OP_EVENT,    16'hFFFF, '0, 2'd3, 1'b0); // wakes the readable waiter only
    send_op(OP_EVENT,    16'hFFFF, '0, 2'd0, 1'b1); // error wakes the empty-mask waiter
    send_op(OP_DISPATCH, '0, '0, '0, 1'b0);        // cursor wraps back to slot zero
    send_op(OP_YIELD,    '0, '0, '0, 1'b0);
    send_op(OP_DISPATCH, '0, '0, '0, 1'b0);
    send_op(OP_FINISH,   '0, '0, '0, 1'b0);
    send_op(OP_DISPATCH, '0, '0, '0, 1'b0);
    send_op(OP_FINISH,   '0, '0, '0, 1'b0);
    send_op(OP_DISPATCH, '0, '0, '0, 1'b0);
  endtask

  // Fill the table, overflow it, park every task on one handle and wake them at once.
  task automatic test_table_full_and_mass_wake();
    logic [HANDLE_W-1:0] shared;
    shared = HANDLE_W'($urandom_range(0, 65535));
    for (int i = 0; i <= TASK_SLOTS; i++) begin
      send_op(OP_SPAWN, '0, '0, '0, 1'b0);
    end
    for (int i = 0; i < TASK_SLOTS; i++) begin
      send_op(OP_DISPATCH, '0, '0, '0, 1'b0);
      send_op(OP_BLOCK, shared, BITS_W'($urandom_range(0, 3)), '0, 1'b0);
      if ($urandom_range(0, 7) == 0) hold_off($urandom_range(1, 17));
    end
    send_op(OP_DISPATCH, '0, '0, '0, 1'b0);
    send_op(OP_EVENT, shared, BITS_W'($urandom_range(0, 3)), '0, 1'b1);
    send_op(OP_SPAWN, '0, '0, '0, 1'b0);
  endtask

  task automatic test_random_traffic();
    for (int phase = 0; phase < 4; phase++) begin
      refresh_handle_pool();
      random_traffic(140, 1'b1, phase[0]);
    end
  endtask

  // Stop sending until every outstanding result is back, then resume.
  task automatic test_drain_pause();
    refresh_handle_pool();
    random_traffic(150, 1'b1, 1'b0);
    wait_for_results();
    hold_off($urandom_range(1, 17));
    random_traffic(150, 1'b1, 1'b1);
  endtask

  // Closing stretch with no gaps at all.
  task automatic test_back_to_back();
    refresh_handle_pool();
    random_traffic(280, 1'b0, 1'b0);
  endtask

  initial begin
    mismatch_count = 0;
    run_valid      = 1'b0;
    run_slot       = 0;
    rr_cursor      = 0;
    for (int i = 0; i < TASK_SLOTS; i++) begin
      slot_st[i]     = SL_FREE;
      slot_handle[i] = '0;
      slot_mask[i]   = '0;
    end
    rst_n         <= 1'b0;
    start         <= 1'b0;
    in_op         <= '0;
    in_io_handle  <= '0;
    in_want_bits  <= '0;
    in_ready_bits <= '0;
    in_io_error   <= 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    // The clearing pass keeps busy high; send_op waits it out.

    test_directed_ops();
    test_table_full_and_mass_wake();
    test_random_traffic();
    test_drain_pause();
    test_back_to_back();

    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+design
design/rrts_pkg.sv
design/rrts_ram.sv
design/rrts_ctrl.sv
design/round_robin_task_scheduler_core.sv
bench/tb.sv
